### rtl/ruc_pkg.sv
package ruc_pkg;

    localparam int MAX_RECTS  = 64;
    localparam int COORD_BITS = 13;
    localparam int CNT_W      = $clog2(MAX_RECTS + 1);
    localparam int IDX_W      = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int AREA_W     = 26;
    localparam int PCT_W      = 7;
    localparam int PROD_W     = AREA_W + PCT_W;
    localparam int CFG_IDX_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 8'd1;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t y1;
        coord_t x1;
        coord_t y0;
        coord_t x0;
    } rect_t;

    typedef struct packed {
        logic   found;
        logic   cov;
        coord_t bound;
    } scan_res_t;

endpackage

### rtl/ruc_store.sv
module ruc_store
    import ruc_pkg::*;
(
    input  logic             aclk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  rect_t            wdata,
    input  logic [IDX_W-1:0] raddr,
    output rect_t            rdata
);

    rect_t mem [MAX_RECTS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/ruc_scan.sv
module ruc_scan
    import ruc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      clr,
    input  logic      en,
    input  logic      mode_y,
    input  rect_t     rect,
    input  coord_t    cur_x,
    input  coord_t    cur_y,
    output scan_res_t res
);

    scan_res_t res_reg, res_next;

    // next bound strictly above the current one, plus segment coverage
    always_comb begin
        coord_t a, b, c;
        a = mode_y ? rect.y0 : rect.x0;
        b = mode_y ? rect.y1 : rect.x1;
        c = mode_y ? cur_y : cur_x;
        res_next = res_reg;
        if (a > c && (!res_next.found || a < res_next.bound)) begin
            res_next.bound = a;
            res_next.found = 1'b1;
        end
        if (b > c && (!res_next.found || b < res_next.bound)) begin
            res_next.bound = b;
            res_next.found = 1'b1;
        end
        if (mode_y && rect.x0 <= cur_x && cur_x < rect.x1
            && rect.y0 <= cur_y && cur_y < rect.y1) begin
            res_next.cov = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            res_reg <= '0;
        end else if (en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### rtl/rectangle_union_coverage_core.sv
// channel | dir | handshake           | payload
// s_      | in  | s_tvalid / s_tready | s_tdata corners, s_tuser has_rect, s_tlast frame_end
// m_      | out | m_tvalid / m_tready | m_tdata area and percent, m_tuser overflow
// cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
// a plain item is taken while idle; a frame end item runs the sweep before the next is taken
// sweep: per x strip one x scan plus one y scan per y segment, each reading every stored
// rectangle through the single store read port, then a multiply and add per strip
// percent: two multiplies and a repeated-subtract divide; reset clears control only
// a result waiting on m_tready holds; loading goes on meanwhile up to the next frame end
module rectangle_union_coverage_core
    import ruc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [55:0]          s_tdata,   // corner_a_x, corner_a_y, corner_b_x, corner_b_y
    input  logic                 s_tuser,   // has_rect
    input  logic                 s_tlast,   // frame_end
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,   // union_area, coverage_percent
    output logic                 m_tuser,   // overflow
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_XSCAN  = 4'd1;
    localparam logic [3:0] ST_XLAST  = 4'd2;
    localparam logic [3:0] ST_XDONE  = 4'd3;
    localparam logic [3:0] ST_YSCAN  = 4'd4;
    localparam logic [3:0] ST_YLAST  = 4'd5;
    localparam logic [3:0] ST_YDONE  = 4'd6;
    localparam logic [3:0] ST_STRIP  = 4'd7;
    localparam logic [3:0] ST_STRADD = 4'd8;
    localparam logic [3:0] ST_PMUL1  = 4'd9;
    localparam logic [3:0] ST_PMUL2  = 4'd10;
    localparam logic [3:0] ST_PDIV   = 4'd11;
    localparam logic [3:0] ST_FIN    = 4'd12;

    logic [3:0]       state_reg, state_next;
    coord_t           width_reg, height_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             drop_reg, drop_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             vld_reg;
    coord_t           cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    coord_t           nx_reg, nx_next, covered_reg, covered_next;
    logic [AREA_W-1:0] area_reg, area_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [AREA_W-1:0] denom_reg, denom_next;
    logic [PCT_W-1:0]  pct_reg, pct_next;
    logic              out_valid_reg;
    logic [AREA_W-1:0] out_area_reg;
    logic [PCT_W-1:0]  out_pct_reg;
    logic              out_ovf_reg;

    // incoming corners, ordered then clamped with the current registers
    coord_t ax, ay, bx, by;
    rect_t  wr_rect, rd_rect;
    logic   in_acc, store_we;

    assign ax = s_tdata[12:0];
    assign ay = s_tdata[25:13];
    assign bx = s_tdata[38:26];
    assign by = s_tdata[51:39];

    function automatic coord_t clamp(input coord_t v, input coord_t lim);
        return (v > lim) ? lim : v;
    endfunction

    always_comb begin
        wr_rect.x0 = clamp((ax < bx) ? ax : bx, width_reg);
        wr_rect.x1 = clamp((ax < bx) ? bx : ax, width_reg);
        wr_rect.y0 = clamp((ay < by) ? ay : by, height_reg);
        wr_rect.y1 = clamp((ay < by) ? by : ay, height_reg);
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc   = s_tvalid && s_tready;
    assign store_we = in_acc && s_tuser && (count_reg < CNT_W'(MAX_RECTS));

    ruc_store u_store (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wr_rect),
        .raddr (rd_idx_reg),
        .rdata (rd_rect)
    );

    // shared compare unit, cleared when a scan begins
    scan_res_t scan_res;
    logic      scan_clr;

    ruc_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (scan_clr),
        .en      (vld_reg),
        .mode_y  (state_reg == ST_YSCAN || state_reg == ST_YLAST),
        .rect    (rd_rect),
        .cur_x   (cur_x_reg),
        .cur_y   (cur_y_reg),
        .res     (scan_res)
    );

    // one multiplier, operands chosen by the sequencer
    logic [AREA_W-1:0]       mul_a;
    logic [COORD_BITS-1:0]   mul_b;
    logic [AREA_W+COORD_BITS-1:0] mul_p;

    always_comb begin
        case (state_reg)
            ST_STRIP: begin
                mul_a = AREA_W'(covered_reg);
                mul_b = nx_reg - cur_x_reg;
            end
            ST_PMUL1: begin
                mul_a = AREA_W'(width_reg);
                mul_b = height_reg;
            end
            default: begin
                mul_a = area_reg;
                mul_b = COORD_BITS'(PCT_MAX);
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    logic [CNT_W-1:0] last_idx;
    assign last_idx = count_reg - CNT_W'(1);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        drop_next    = drop_reg;
        rd_idx_next  = rd_idx_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        nx_next      = nx_reg;
        covered_next = covered_reg;
        area_next    = area_reg;
        prod_next    = prod_reg;
        denom_next   = denom_reg;
        pct_next     = pct_reg;
        scan_clr     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tuser) begin
                        if (store_we) begin
                            count_next = count_reg + CNT_W'(1);
                        end else begin
                            drop_next = 1'b1;
                        end
                    end
                    if (s_tlast) begin
                        area_next  = '0;
                        cur_x_next = '0;
                        rd_idx_next = '0;
                        scan_clr   = 1'b1;
                        state_next = (count_next == '0) ? ST_PMUL1 : ST_XSCAN;
                    end
                end
            end
            ST_XSCAN, ST_YSCAN: begin
                if (rd_idx_reg == last_idx[IDX_W-1:0]) begin
                    state_next = (state_reg == ST_XSCAN) ? ST_XLAST : ST_YLAST;
                end else begin
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
            end
            ST_XLAST: state_next = ST_XDONE;
            ST_YLAST: state_next = ST_YDONE;
            ST_XDONE: begin
                rd_idx_next = '0;
                if (!scan_res.found) begin
                    state_next = ST_PMUL1;
                end else begin
                    nx_next      = scan_res.bound;
                    cur_y_next   = '0;
                    covered_next = '0;
                    scan_clr     = 1'b1;
                    state_next   = ST_YSCAN;
                end
            end
            ST_YDONE: begin
                rd_idx_next = '0;
                if (scan_res.found) begin
                    if (scan_res.cov) begin
                        covered_next = covered_reg + (scan_res.bound - cur_y_reg);
                    end
                    cur_y_next = scan_res.bound;
                    scan_clr   = 1'b1;
                    state_next = ST_YSCAN;
                end else begin
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP: begin
                prod_next  = PROD_W'(mul_p);
                state_next = ST_STRADD;
            end
            ST_STRADD: begin
                area_next  = area_reg + prod_reg[AREA_W-1:0];
                cur_x_next = nx_reg;
                rd_idx_next = '0;
                scan_clr   = 1'b1;
                state_next = ST_XSCAN;
            end
            ST_PMUL1: begin
                prod_next  = PROD_W'(mul_p);
                state_next = ST_PMUL2;
            end
            ST_PMUL2: begin
                denom_next = prod_reg[AREA_W-1:0];
                prod_next  = PROD_W'(mul_p);
                pct_next   = '0;
                state_next = ST_PDIV;
            end
            ST_PDIV: begin
                // repeated subtraction, saturating at a full screen
                if (denom_reg == '0 || count_reg == '0 || pct_reg == PCT_MAX
                    || prod_reg < PROD_W'(denom_reg)) begin
                    state_next = ST_FIN;
                end else begin
                    prod_next = prod_reg - PROD_W'(denom_reg);
                    pct_next  = pct_reg + PCT_W'(1);
                end
            end
            ST_FIN: begin
                if (!out_valid_reg || m_tready) begin
                    count_next = '0;
                    drop_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            vld_reg       <= 1'b0;
            rd_idx_reg    <= '0;
            width_reg     <= 13'd1920;
            height_reg    <= 13'd1080;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            drop_reg   <= drop_next;
            rd_idx_reg <= rd_idx_next;
            vld_reg    <= (state_reg == ST_XSCAN) || (state_reg == ST_YSCAN);
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_SCREEN_WIDTH) begin
                    width_reg <= cfg_data[COORD_BITS-1:0];
                end else if (cfg_index == REG_SCREEN_HEIGHT) begin
                    height_reg <= cfg_data[COORD_BITS-1:0];
                end
            end
            if (state_reg == ST_FIN && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        nx_reg      <= nx_next;
        covered_reg <= covered_next;
        area_reg    <= area_next;
        prod_reg    <= prod_next;
        denom_reg   <= denom_next;
        pct_reg     <= pct_next;
        if (state_reg == ST_FIN && (!out_valid_reg || m_tready)) begin
            out_area_reg <= area_reg;
            out_pct_reg  <= pct_reg;
            out_ovf_reg  <= drop_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_pct_reg, out_area_reg};
    assign m_tuser  = out_ovf_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_RECTS)) else $error("rect count above capacity");
    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_XSCAN || state_reg == ST_YSCAN) |-> count_reg != '0)
        else $error("scan started on an empty frame");
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_pct_reg <= PCT_MAX) else $error("percent above full");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PDIV) |=> !s_tready) else $error("ready during percent step");
`endif

endmodule

### verif/tb_top.sv
module tb_top
    import ruc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // result fields as they travel on m_tdata / m_tuser
    typedef struct {
        logic [AREA_W-1:0] area;
        logic [PCT_W-1:0]  pct;
        logic              ovf;
    } coverage_t;

    // one row of the directed part: a register write or an item
    typedef struct {
        bit                  is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [15:0]         val;
        coord_t              ax, ay, bx, by;
        bit                  has, fend;
        bit                  typed;
        coverage_t           exp;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [55:0]          s_tdata = '0;   // corner_a_x, corner_a_y, corner_b_x, corner_b_y
    logic                 s_tuser = 1'b0; // has_rect
    logic                 s_tlast = 1'b0; // frame_end
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [39:0]          m_tdata;        // union_area, coverage_percent
    logic                 m_tuser;        // overflow
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;

    rectangle_union_coverage_core dut (.*);

    always #1 aclk = ~aclk;

    // shadow of the block: registers and the rectangles of the open frame
    coord_t     scr_w = 13'd1920, scr_h = 13'd1080;
    rect_t      frame_rects[MAX_RECTS];
    int         frame_cnt = 0;
    bit         frame_dropped = 0;

    coverage_t  pending_results[$];
    int         errors = 0;
    int         frames_checked = 0, ovf_frames = 0, cfg_writes = 0, items_sent = 0;
    bit         quiet = 0;      // no idling on either side near the end
    bit         hold_req = 0, hold_done = 0;
    int         hold_left = 0, stall_left = 0;
    dir_row_t   rows[$];

    // sorted insert without duplicates
    function automatic void add_bound(ref int unsigned q[$], input int unsigned v);
        int i;
        i = 0;
        while (i < q.size() && q[i] < v) i++;
        if (i < q.size() && q[i] == v) return;
        q.insert(i, v);
    endfunction

    // exact union area by x strips and y segments, then the percent
    function automatic coverage_t predict_frame();
        int unsigned xs[$], ys[$];
        longint      area, covered, denom, pct;
        bit          hit;
        coverage_t   r;
        area = 0;
        for (int k = 0; k < frame_cnt; k++) begin
            add_bound(xs, frame_rects[k].x0);
            add_bound(xs, frame_rects[k].x1);
            add_bound(ys, frame_rects[k].y0);
            add_bound(ys, frame_rects[k].y1);
        end
        for (int i = 0; i + 1 < xs.size(); i++) begin
            covered = 0;
            for (int s = 0; s + 1 < ys.size(); s++) begin
                hit = 0;
                for (int k = 0; k < frame_cnt; k++)
                    if (frame_rects[k].x0 <= xs[i] && frame_rects[k].x1 >= xs[i+1] &&
                        frame_rects[k].y0 <= ys[s] && ys[s+1] <= frame_rects[k].y1)
                        hit = 1;
                if (hit) covered += ys[s+1] - ys[s];
            end
            area += covered * (xs[i+1] - xs[i]);
        end
        denom = longint'(scr_w) * longint'(scr_h);
        pct = 0;
        if (frame_cnt > 0 && denom != 0) begin
            pct = area * 100 / denom;
            if (pct > 100) pct = 100;
        end
        r.area = area[AREA_W-1:0];
        r.pct  = pct[PCT_W-1:0];
        r.ovf  = frame_dropped;
        return r;
    endfunction

    function automatic coord_t clamp_coord(coord_t v, coord_t lim);
        return (v > lim) ? lim : v;
    endfunction

    // state update for one accepted item; queues the result on frame end
    function automatic void track_item(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                       bit has, bit fend);
        if (has) begin
            if (frame_cnt < MAX_RECTS) begin
                frame_rects[frame_cnt].x0 = clamp_coord(ax < bx ? ax : bx, scr_w);
                frame_rects[frame_cnt].x1 = clamp_coord(ax < bx ? bx : ax, scr_w);
                frame_rects[frame_cnt].y0 = clamp_coord(ay < by ? ay : by, scr_h);
                frame_rects[frame_cnt].y1 = clamp_coord(ay < by ? by : ay, scr_h);
                frame_cnt++;
            end else begin
                frame_dropped = 1;
            end
        end
        if (fend) begin
            pending_results.insert(pending_results.size(), predict_frame());
            frame_cnt = 0;
            frame_dropped = 0;
        end
    endfunction

    // offer one item and hold it until accepted
    task automatic send_item(coord_t ax, coord_t ay, coord_t bx, coord_t by, bit has, bit fend);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, by, bx, ay, ax};
        s_tuser  <= has;
        s_tlast  <= fend;
        do @(posedge aclk); while (!s_tready);
        track_item(ax, ay, bx, by, has, fend);
        items_sent++;
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    // all results in, then an idle wait so a pure load item has surely settled
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_SCREEN_WIDTH)  scr_w = val[COORD_BITS-1:0];
        if (idx == REG_SCREEN_HEIGHT) scr_h = val[COORD_BITS-1:0];
        cfg_writes++;
    endtask

    function automatic void row_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        dir_row_t r;
        r = '{default: '0};
        r.is_cfg = 1; r.idx = idx; r.val = val;
        rows.insert(rows.size(), r);
    endfunction

    function automatic void row_item(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                     bit has, bit fend, bit typed = 0,
                                     int area = 0, int pct = 0, bit ovf = 0);
        dir_row_t r;
        r = '{default: '0};
        r.ax = ax; r.ay = ay; r.bx = bx; r.by = by; r.has = has; r.fend = fend;
        r.typed = typed;
        r.exp.area = AREA_W'(area); r.exp.pct = PCT_W'(pct); r.exp.ovf = ovf;
        rows.insert(rows.size(), r);
    endfunction

    // mostly inside the screen, sometimes anywhere in the field range
    function automatic coord_t rand_coord(coord_t lim);
        if ($urandom_range(0, 1)) return coord_t'($urandom_range(0, lim));
        return coord_t'($urandom_range(0, 8191));
    endfunction

    // long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_left <= 20000;
            hold_done <= 1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result side: check accepted items, then pick ready for the next cycle
    always @(posedge aclk) begin
        coverage_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result area=%0d pct=%0d ovf=%0b", $time,
                             m_tdata[25:0], m_tdata[32:26], m_tuser);
                    errors++;
                end else begin
                    e = pending_results.pop_front();
                    frames_checked++;
                    if (e.ovf) ovf_frames++;
                    if (m_tdata[25:0] !== e.area) begin
                        $display("%0t: union_area expected %0d actual %0d", $time,
                                 e.area, m_tdata[25:0]);
                        errors++;
                    end
                    if (m_tdata[32:26] !== e.pct) begin
                        $display("%0t: coverage_percent expected %0d actual %0d", $time,
                                 e.pct, m_tdata[32:26]);
                        errors++;
                    end
                    if (m_tuser !== e.ovf) begin
                        $display("%0t: overflow expected %0b actual %0b", $time,
                                 e.ovf, m_tuser);
                        errors++;
                    end
                end
            end
            // ready: long hold, random stall bursts, or steady when quiet
            if (hold_left > 1 || (hold_req && !hold_done)) begin
                m_tready <= 1'b0;
            end else if (quiet) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #20_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        int        n;
        bit        big;
        rect_t     pool[2];
        coord_t    cx0, cy0, cx1, cy1;
        int        frame_no;

        // directed rows, reset screen 1920 x 1080
        row_item(0, 0, 0, 0, 0, 1, 1, 0, 0, 0);                 // empty frame
        row_item(100, 200, 0, 0, 1, 1, 1, 20000, 0, 0);         // swapped corners
        row_item(8191, 8191, 0, 0, 1, 1, 1, 2073600, 100, 0);   // clamp to full screen
        row_item(5, 5, 5, 900, 1, 1, 1, 0, 0, 0);               // zero width adds nothing
        row_item(0, 0, 10, 10, 1, 0);                           // overlapping pair
        row_item(15, 15, 5, 5, 1, 0);
        row_item(8191, 0, 0, 8191, 0, 1);                       // corners ignored, frame end
        row_cfg(REG_SCREEN_WIDTH, 16'd8191);
        row_cfg(REG_SCREEN_HEIGHT, 16'd8191);
        row_item(8191, 8191, 0, 0, 1, 1, 1, 67092481, 100, 0);  // largest area
        row_item(0, 8191, 8191, 0, 1, 0);
        row_item(4000, 10, 10, 4000, 1, 1);
        row_cfg(REG_SCREEN_WIDTH, 16'd1);
        row_cfg(REG_SCREEN_HEIGHT, 16'd1);
        row_item(0, 0, 8191, 8191, 1, 1, 1, 1, 100, 0);         // one-pixel screen
        row_cfg(REG_SCREEN_WIDTH, 16'd8191);
        row_cfg(REG_SCREEN_HEIGHT, 16'd8191);
        row_item(0, 0, 4000, 4000, 1, 0);                       // loaded under the big clamp
        row_cfg(REG_SCREEN_WIDTH, 16'd100);                     // shrink mid-frame
        row_cfg(REG_SCREEN_HEIGHT, 16'd100);
        row_item(0, 0, 0, 0, 0, 1, 1, 16000000, 100, 0);        // percent saturates
        row_cfg(REG_SCREEN_WIDTH, 16'd0);                       // zero screen area
        row_item(0, 0, 50, 50, 1, 1, 1, 0, 0, 0);
        row_cfg(8'd2, 16'd5);                                   // unknown index, ignored
        row_item(0, 0, 50, 50, 1, 1, 1, 0, 0, 0);
        row_cfg(REG_SCREEN_WIDTH, 16'd1920);
        row_cfg(REG_SCREEN_HEIGHT, 16'd1080);
        row_item(8191, 8191, 0, 0, 1, 1, 1, 2073600, 100, 0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                write_reg(rows[i].idx, rows[i].val);
            end else begin
                sender_gap();
                send_item(rows[i].ax, rows[i].ay, rows[i].bx, rows[i].by,
                          rows[i].has, rows[i].fend);
                if (rows[i].typed) pending_results[$] = rows[i].exp;
            end
        end

        // random frames: mostly a few rectangles, now and then a store-filling one
        frame_no = 0;
        while (items_sent < 1145) begin
            if (items_sent > 1050) quiet = 1;
            if (frame_no % 12 == 11 && !quiet) begin
                case ($urandom_range(0, 3))
                    0:       begin write_reg(REG_SCREEN_WIDTH, 16'd8191);
                                   write_reg(REG_SCREEN_HEIGHT, 16'd1); end
                    1:       begin write_reg(REG_SCREEN_WIDTH, 16'd1);
                                   write_reg(REG_SCREEN_HEIGHT, 16'd8191); end
                    default: begin write_reg(REG_SCREEN_WIDTH, 16'($urandom_range(1, 8191)));
                                   write_reg(REG_SCREEN_HEIGHT, 16'($urandom_range(1, 8191)));
                             end
                endcase
            end
            if (frame_no == 6) hold_req = 1;       // block fills and stalls its input
            if (frame_no == 14) begin              // sender waits for every result
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_results.size() != 0) @(posedge aclk);
            end
            big = ($urandom_range(0, 19) == 0);
            if (big) begin
                // few distinct bounds keep the sweep short
                for (int p = 0; p < 2; p++) begin
                    pool[p].x0 = rand_coord(scr_w); pool[p].y0 = rand_coord(scr_h);
                    pool[p].x1 = rand_coord(scr_w); pool[p].y1 = rand_coord(scr_h);
                end
                n = $urandom_range(MAX_RECTS - 2, MAX_RECTS + 6);
            end else begin
                n = $urandom_range(0, 8);
            end
            for (int k = 0; k < n; k++) begin
                if (big) begin
                    int p;
                    p = $urandom_range(0, 1);
                    cx0 = pool[p].x0; cy0 = pool[p].y0; cx1 = pool[p].x1; cy1 = pool[p].y1;
                end else begin
                    cx0 = rand_coord(scr_w); cy0 = rand_coord(scr_h);
                    cx1 = rand_coord(scr_w); cy1 = rand_coord(scr_h);
                end
                if ($urandom_range(0, 15) == 0) begin
                    sender_gap();                  // noise item, corners ignored
                    send_item(coord_t'($urandom_range(0, 8191)),
                              coord_t'($urandom_range(0, 8191)),
                              coord_t'($urandom_range(0, 8191)),
                              coord_t'($urandom_range(0, 8191)), 0, 0);
                end
                sender_gap();
                send_item(cx0, cy0, cx1, cy1, 1, (k == n - 1) && $urandom_range(0, 9) < 7);
            end
            if (frame_cnt > 0 || n == 0 || frame_dropped) begin
                sender_gap();
                send_item(coord_t'($urandom_range(0, 8191)), coord_t'($urandom_range(0, 8191)),
                          coord_t'($urandom_range(0, 8191)), coord_t'($urandom_range(0, 8191)),
                          0, 1);
            end
            frame_no++;
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("covered %0d items, %0d frames checked, %0d with dropped rectangles",
                 items_sent, frames_checked, ovf_frames);
        $display("%0d register writes incl. extremes, zero size and mid-frame change",
                 cfg_writes);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/ruc_pkg.sv
rtl/ruc_store.sv
rtl/ruc_scan.sv
rtl/rectangle_union_coverage_core.sv
verif/tb_top.sv
